// ===== rtl/core/trapezoidal_shaping_filter_top_macros.svh =====
// Assertion macros for the trapezoidal shaping filter.
`ifndef TRAPEZOIDAL_SHAPING_FILTER_TOP_MACROS_SVH
`define TRAPEZOIDAL_SHAPING_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TSF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("trapezoidal filter check failed");
`define TSF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("trapezoidal filter check failed");
`else
`define TSF_ASSERT(lbl, clk, rstn, prop)
`define TSF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/tsf_pkg.sv =====
// Types and constants of the trapezoidal shaping filter.
`timescale 1ns / 1ps

package tsf_pkg;

  localparam int ACC_W       = 27;
  localparam int RISE_W      = 11;
  localparam int FLAT_W      = 12;
  localparam int DLY_W       = 13;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_TDATA_W = 32;
  localparam int NUM_TAPS    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_LEN = 1'b0,
    CFG_FLAT_LEN = 1'b1
  } cfg_idx_e;

  typedef logic [DLY_W-1:0] dly_t;

endpackage

// ===== rtl/core/trapezoidal_shaping_filter_top.sv =====
// Trapezoidal shaping filter: sample history in block memory, running accumulator.
//
//   Port group   Direction   Carries
//   s_axis       in          tdata: sample; tuser: first_sample
//   m_axis       out         tdata: trap_value
//   cfg          in          register writes, index 0 rise_len, index 1 flat_len
//
// A sample per cycle unless m_axis stalls; the result goes via stage 1 to acc_q.
// The rate is set by the two history memories, which give three tap reads per cycle.
// The fill count gates every history read, so the memories need no clearing after reset.
// A stall on m_axis holds the output register; s_axis stays ready while a stage is empty.
`timescale 1ns / 1ps
`include "trapezoidal_shaping_filter_top_macros.svh"

module trapezoidal_shaping_filter_top
  import tsf_pkg::*;
#(
  parameter int MAX_DELAY   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Bits from 0: sample.
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // Bit 0: first_sample.
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Bits from 0: trap_value.
  output logic [OUT_TDATA_W-1:0]                m_axis_tdata,
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_idx_i,
  input  logic [CFG_W-1:0]                      cfg_data_i
);

  localparam int AW      = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int SEEN_W  = $clog2(MAX_DELAY + 1);
  localparam int CMP_W   = (SEEN_W > DLY_W) ? SEEN_W : DLY_W;
  localparam logic [SEEN_W-1:0] SeenMax = SEEN_W'(MAX_DELAY);
  localparam logic [AW-1:0]     WpLast  = AW'(MAX_DELAY - 1);
  localparam logic [CMP_W-1:0]  DepthC  = CMP_W'(MAX_DELAY);

  logic [SAMPLE_BITS-1:0] hist_a [MAX_DELAY];
  logic [SAMPLE_BITS-1:0] hist_b [MAX_DELAY];

  logic [RISE_W-1:0] rise_q, rise_d;
  logic [FLAT_W-1:0] flat_q, flat_d;
  dly_t              dly_q [NUM_TAPS];
  dly_t              dly_d [NUM_TAPS];
  logic [RISE_W-1:0] rise_eff;

  logic [AW-1:0]     wp_q, wp_d;
  logic [SEEN_W-1:0] seen_q, seen_d, seen_eff;

  logic [SAMPLE_BITS-1:0] x_in;
  logic                   in_fire;
  logic                   s1_ld, s2_ld;
  logic [AW-1:0]          rd_addr [NUM_TAPS];
  logic [NUM_TAPS-1:0]    tap_vld;

  logic                   v1_q, first1_q;
  logic [SAMPLE_BITS-1:0] x1_q;
  logic [NUM_TAPS-1:0]    tap_vld_q;
  logic [SAMPLE_BITS-1:0] rd_q [NUM_TAPS];

  logic [ACC_W-1:0] x1_ext, t_ext0, t_ext1, t_ext2, acc_base, acc_d, acc_q;
  logic             v2_q;

  assign x_in    = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s2_ld   = !v2_q || m_axis_tready;
  assign s1_ld   = !v1_q || s2_ld;
  assign in_fire = s_axis_tvalid && s1_ld;

  assign s_axis_tready = s1_ld;
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - ACC_W){1'b0}}, acc_q};

  // Configuration registers and the three tap delays derived from them.
  always_comb begin
    rise_d = rise_q;
    flat_d = flat_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RISE_LEN: rise_d = cfg_data_i[RISE_W-1:0];
        CFG_FLAT_LEN: flat_d = cfg_data_i[FLAT_W-1:0];
      endcase
    end
  end

  assign rise_eff = (rise_d == '0) ? RISE_W'(1) : rise_d;
  assign dly_d[0] = DLY_W'(rise_eff);
  assign dly_d[1] = DLY_W'(rise_eff) + DLY_W'(flat_d);
  assign dly_d[2] = DLY_W'({rise_eff, 1'b0}) + DLY_W'(flat_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q   <= RISE_W'(1);
      flat_q   <= '0;
      dly_q[0] <= DLY_W'(1);
      dly_q[1] <= DLY_W'(1);
      dly_q[2] <= DLY_W'(2);
    end else begin
      rise_q <= rise_d;
      flat_q <= flat_d;
      for (int i = 0; i < NUM_TAPS; i++) begin
        dly_q[i] <= dly_d[i];
      end
    end
  end

  // Tap addresses and fill-count gating.
  assign seen_eff = s_axis_tuser ? '0 : seen_q;
  assign seen_d   = (seen_eff < SeenMax) ? seen_eff + SEEN_W'(1) : seen_eff;
  assign wp_d     = (wp_q == WpLast) ? '0 : wp_q + AW'(1);

  always_comb begin
    logic [CMP_W-1:0] wp_ext;
    logic [CMP_W-1:0] d_ext;
    logic [CMP_W-1:0] diff;
    wp_ext = CMP_W'(wp_q);
    for (int i = 0; i < NUM_TAPS; i++) begin
      d_ext      = CMP_W'(dly_q[i]);
      tap_vld[i] = d_ext <= CMP_W'(seen_eff);
      diff       = (wp_ext >= d_ext) ? wp_ext - d_ext : wp_ext + DepthC - d_ext;
      rd_addr[i] = diff[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      seen_q <= '0;
    end else if (in_fire) begin
      wp_q   <= wp_d;
      seen_q <= seen_d;
    end
  end

  // History memories, read-first; both hold the same samples.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hist_a[wp_q] <= x_in;
      hist_b[wp_q] <= x_in;
    end
    if (s1_ld) begin
      rd_q[0] <= hist_a[rd_addr[0]];
      rd_q[1] <= hist_a[rd_addr[1]];
      rd_q[2] <= hist_b[rd_addr[2]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s1_ld) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x1_q      <= x_in;
      first1_q  <= s_axis_tuser;
      tap_vld_q <= tap_vld;
    end
  end

  // Accumulator update.
  assign x1_ext = {{(ACC_W - SAMPLE_BITS){x1_q[SAMPLE_BITS-1]}}, x1_q};
  assign t_ext0 = tap_vld_q[0] ? {{(ACC_W - SAMPLE_BITS){rd_q[0][SAMPLE_BITS-1]}}, rd_q[0]} : '0;
  assign t_ext1 = tap_vld_q[1] ? {{(ACC_W - SAMPLE_BITS){rd_q[1][SAMPLE_BITS-1]}}, rd_q[1]} : '0;
  assign t_ext2 = tap_vld_q[2] ? {{(ACC_W - SAMPLE_BITS){rd_q[2][SAMPLE_BITS-1]}}, rd_q[2]} : '0;
  assign acc_base = first1_q ? '0 : acc_q;
  assign acc_d    = acc_base + x1_ext - t_ext0 - t_ext1 + t_ext2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else if (s2_ld) begin
      v2_q <= v1_q;
      if (v1_q) begin
        acc_q <= acc_d;
      end
    end
  end

  `TSF_ASSERT(a_first_restarts, clk_i, rst_ni, (s2_ld && v1_q && first1_q) |=> (acc_q == $past(x1_ext)))
  `TSF_ASSERT(a_fill_bounded, clk_i, rst_ni, seen_q <= SeenMax)
  `TSF_ASSERT(a_taps_ordered, clk_i, rst_ni, (v1_q && tap_vld_q[2]) |-> (tap_vld_q[1] && tap_vld_q[0]))
  `TSF_ASSERT(a_ready_when_empty, clk_i, rst_ni, (!v1_q || !v2_q) |-> s_axis_tready)

endmodule
